// File: hdl/affine_2d_vertex_transform_macros.svh
// ----------------------------------------------------------------------------
// affine_2d_vertex_transform_macros
// Assertion macros used by the vertex transform top module. They expect clk
// and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef AFFINE_2D_VERTEX_TRANSFORM_MACROS_SVH
`define AFFINE_2D_VERTEX_TRANSFORM_MACROS_SVH

// same-cycle implication
`define AVT_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AVT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/avt_pkg.sv
// ----------------------------------------------------------------------------
// avt_pkg
// Shared constants and types of the 2D vertex transform pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package avt_pkg;

	localparam int NUM_STAGES = 8;

	localparam int ST_1 = 0;
	localparam int ST_2 = 1;
	localparam int ST_3 = 2;
	localparam int ST_4 = 3;
	localparam int ST_5 = 4;
	localparam int ST_6 = 5;
	localparam int ST_7 = 6;
	localparam int ST_8 = 7;

	localparam int ANGLE_W   = 16;
	localparam int TRIG_W    = 15;
	localparam int SC_W      = TRIG_W + 2;
	localparam int COEF_W    = TRIG_W + 3;
	localparam int FRAC_BITS = 16;

	localparam logic signed [COEF_W-1:0] COEF_ONE = 18'sd65536;

	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_X = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ANGLE    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PIVOT_X  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_PIVOT_Y  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SCALE    = 3'd6;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_TRANSLATE = 2'd0;
	localparam mode_t MODE_ROTATE    = 2'd1;
	localparam mode_t MODE_SCALE     = 2'd2;
	localparam mode_t MODE_IDENTITY  = 2'd3;

	typedef logic [1:0] quad_t;
	localparam quad_t QUAD_0 = 2'd0;
	localparam quad_t QUAD_1 = 2'd1;
	localparam quad_t QUAD_2 = 2'd2;
	localparam quad_t QUAD_3 = 2'd3;

	typedef logic [NUM_STAGES-1:0] stage_vec_t;

	typedef struct packed {
		stage_vec_t adv;
	} pipe_ctl_t;

endpackage

`default_nettype wire

// File: hdl/avt_sincos.sv
// ----------------------------------------------------------------------------
// avt_sincos
// Quarter-wave sine ROM and quadrant folding; sine and cosine in Q2.15.
// ----------------------------------------------------------------------------
`default_nettype none

module avt_sincos
	import avt_pkg::*;
#(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                     clk,
	input  pipe_ctl_t                ctl,
	input  logic [ANGLE_W-1:0]       angle,
	output logic signed [SC_W-1:0]   sin_v,
	output logic signed [SC_W-1:0]   cos_v
);

	localparam int ROM_N   = 1 << SINE_TABLE_BITS;
	localparam int ROM_DIV = 2 * ROM_N;
	localparam int IDX_W   = SINE_TABLE_BITS + 1;
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef logic [TRIG_W-1:0] rom_t [ROM_N+1];

	function automatic rom_t build_rom();
		rom_t              rom;
		logic [63:0]       xa;
		logic [63:0]       x2;
		logic [63:0]       term;
		logic signed [63:0] acc;
		logic signed [63:0] rnd;
		for (int k = 0; k <= ROM_N; k++) begin
			xa = (64'(k) * PI_Q30 + 64'(ROM_N)) / 64'(ROM_DIV);
			x2 = (xa * xa) >> 30;
			term = xa;
			acc = signed'(xa);
			for (int n = 1; n <= 7; n++) begin
				term = (term * x2) >> 30;
				case (n)
					1: term = term / 64'd6;
					2: term = term / 64'd20;
					3: term = term / 64'd42;
					4: term = term / 64'd72;
					5: term = term / 64'd110;
					6: term = term / 64'd156;
					default: term = term / 64'd210;
				endcase
				if (n[0]) begin
					acc = acc - signed'(term);
				end else begin
					acc = acc + signed'(term);
				end
			end
			if (acc < 0) begin
				acc = '0;
			end
			rnd = ((acc <<< 15) + (64'sd1 <<< 29)) >>> 30;
			rom[k] = (rnd > 64'sd32767) ? {TRIG_W{1'b1}} : rnd[TRIG_W-1:0];
		end
		return rom;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic [IDX_W-1:0]        idx_lo;
	logic [IDX_W-1:0]        idx_hi;
	logic [TRIG_W-1:0]       lo_s1;
	logic [TRIG_W-1:0]       hi_s1;
	quad_t                   quad_s1;
	logic signed [SC_W-1:0]  lo_v;
	logic signed [SC_W-1:0]  hi_v;
	logic signed [SC_W-1:0]  sin_d;
	logic signed [SC_W-1:0]  cos_d;
	logic signed [SC_W-1:0]  sin_s2;
	logic signed [SC_W-1:0]  cos_s2;

	assign idx_lo = {1'b0, angle[ANGLE_W-3 -: SINE_TABLE_BITS]};
	assign idx_hi = IDX_W'(ROM_N) - idx_lo;

	always_ff @(posedge clk) begin
		if (ctl.adv[ST_1]) begin
			lo_s1   <= SINE_ROM[idx_lo];
			hi_s1   <= SINE_ROM[idx_hi];
			quad_s1 <= angle[ANGLE_W-1 -: 2];
		end
	end

	always_comb begin
		lo_v = SC_W'(lo_s1);
		hi_v = SC_W'(hi_s1);
		unique case (quad_s1)
			QUAD_0: begin
				sin_d = lo_v;
				cos_d = hi_v;
			end
			QUAD_1: begin
				sin_d = hi_v;
				cos_d = -lo_v;
			end
			QUAD_2: begin
				sin_d = -lo_v;
				cos_d = -hi_v;
			end
			QUAD_3: begin
				sin_d = -hi_v;
				cos_d = lo_v;
			end
			default: begin
				sin_d = '0;
				cos_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[ST_2]) begin
			sin_s2 <= sin_d;
			cos_s2 <= cos_d;
		end
	end

	assign sin_v = sin_s2;
	assign cos_v = cos_s2;

endmodule

`default_nettype wire

// File: hdl/avt_pivot.sv
// ----------------------------------------------------------------------------
// avt_pivot
// Translation column of the rotation matrix: pivot times (1 - cos) and sin,
// rounded to Q.16 and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module avt_pivot
	import avt_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  logic                           clk,
	input  pipe_ctl_t                      ctl,
	input  logic signed [SC_W-1:0]         sin_v,
	input  logic signed [SC_W-1:0]         cos_v,
	input  logic signed [COORD_WIDTH-1:0]  pivot_x,
	input  logic signed [COORD_WIDTH-1:0]  pivot_y,
	output logic signed [COORD_WIDTH-1:0]  tx,
	output logic signed [COORD_WIDTH-1:0]  ty,
	output logic                           sat
);

	localparam int CW = COORD_WIDTH;
	localparam int PW = CW + COEF_W;
	localparam int SW = PW + 1;
	localparam int QW = SW - TRIG_W;
	localparam logic signed [COEF_W-1:0] COEF_HALF_TURN = 18'sd32768;
	localparam logic signed [SW-1:0] HALF = SW'(1) <<< (TRIG_W - 1);
	localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

	logic signed [COEF_W-1:0] omc;
	logic signed [COEF_W-1:0] s_pos;
	logic signed [COEF_W-1:0] s_neg;
	logic signed [PW-1:0]     pa_s3;
	logic signed [PW-1:0]     pb_s3;
	logic signed [PW-1:0]     pc_s3;
	logic signed [PW-1:0]     pd_s3;
	logic signed [SW-1:0]     sx_s4;
	logic signed [SW-1:0]     sy_s4;
	logic signed [QW-1:0]     qx;
	logic signed [QW-1:0]     qy;
	logic                     fit_x;
	logic                     fit_y;
	logic signed [CW-1:0]     tx_s5;
	logic signed [CW-1:0]     ty_s5;
	logic                     sat_s5;

	assign omc   = COEF_HALF_TURN - COEF_W'(cos_v);
	assign s_pos = COEF_W'(sin_v);
	assign s_neg = -s_pos;

	always_ff @(posedge clk) begin
		if (ctl.adv[ST_3]) begin
			pa_s3 <= PW'(pivot_x) * PW'(omc);
			pb_s3 <= PW'(pivot_y) * PW'(s_pos);
			pc_s3 <= PW'(pivot_y) * PW'(omc);
			pd_s3 <= PW'(pivot_x) * PW'(s_neg);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[ST_4]) begin
			sx_s4 <= SW'(pa_s3) + SW'(pb_s3) + HALF;
			sy_s4 <= SW'(pc_s3) + SW'(pd_s3) + HALF;
		end
	end

	assign qx    = sx_s4[SW-1:TRIG_W];
	assign qy    = sy_s4[SW-1:TRIG_W];
	assign fit_x = (qx[QW-1:CW-1] == '0) || (qx[QW-1:CW-1] == '1);
	assign fit_y = (qy[QW-1:CW-1] == '0) || (qy[QW-1:CW-1] == '1);

	always_ff @(posedge clk) begin
		if (ctl.adv[ST_5]) begin
			tx_s5  <= fit_x ? qx[CW-1:0] : (qx[QW-1] ? C_MIN : C_MAX);
			ty_s5  <= fit_y ? qy[CW-1:0] : (qy[QW-1] ? C_MIN : C_MAX);
			sat_s5 <= !fit_x || !fit_y;
		end
	end

	assign tx  = tx_s5;
	assign ty  = ty_s5;
	assign sat = sat_s5;

endmodule

`default_nettype wire

// File: hdl/avt_row.sv
// ----------------------------------------------------------------------------
// avt_row
// One matrix row: two narrow coefficient products, one full-width product
// split into halves, rounding to Q.16 and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module avt_row
	import avt_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  logic                           clk,
	input  pipe_ctl_t                      ctl,
	input  logic signed [COEF_W-1:0]       coef_x,
	input  logic signed [COEF_W-1:0]       coef_y,
	input  logic signed [COORD_WIDTH-1:0]  vx,
	input  logic signed [COORD_WIDTH-1:0]  vy,
	input  logic signed [COORD_WIDTH-1:0]  mul_a,
	input  logic signed [COORD_WIDTH-1:0]  mul_b,
	output logic signed [COORD_WIDTH-1:0]  coord,
	output logic                           sat
);

	localparam int CW    = COORD_WIDTH;
	localparam int PW    = CW + COEF_W;
	localparam int NW    = PW + 1;
	localparam int LO_W  = CW / 2;
	localparam int HI_W  = CW - LO_W;
	localparam int PLO_W = CW + LO_W + 1;
	localparam int PHI_W = CW + HI_W;
	localparam int AW    = ((2 * CW > NW) ? 2 * CW : NW) + 1;
	localparam int QW    = AW - FRAC_BITS;
	localparam logic signed [AW-1:0] HALF = AW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

	logic signed [PW-1:0]    mx_s3;
	logic signed [PW-1:0]    my_s3;
	logic signed [NW-1:0]    ns_s4;
	logic signed [NW-1:0]    ns_s5;
	logic signed [NW-1:0]    ns_s6;
	logic signed [PLO_W-1:0] plo_s6;
	logic signed [PHI_W-1:0] phi_s6;
	logic signed [AW-1:0]    acc_s7;
	logic signed [AW-1:0]    rnd;
	logic signed [QW-1:0]    q;
	logic                    fit;
	logic signed [CW-1:0]    coord_s8;
	logic                    sat_s8;

	always_ff @(posedge clk) begin
		if (ctl.adv[ST_3]) begin
			mx_s3 <= PW'(vx) * PW'(coef_x);
			my_s3 <= PW'(vy) * PW'(coef_y);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[ST_4]) begin
			ns_s4 <= NW'(mx_s3) + NW'(my_s3);
		end
		if (ctl.adv[ST_5]) begin
			ns_s5 <= ns_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[ST_6]) begin
			plo_s6 <= PLO_W'(mul_a) * PLO_W'($signed({1'b0, mul_b[LO_W-1:0]}));
			phi_s6 <= PHI_W'(mul_a) * PHI_W'($signed(mul_b[CW-1:LO_W]));
			ns_s6  <= ns_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[ST_7]) begin
			acc_s7 <= (AW'(phi_s6) <<< LO_W) + AW'(plo_s6) + AW'(ns_s6);
		end
	end

	assign rnd = acc_s7 + HALF;
	assign q   = rnd[AW-1:FRAC_BITS];
	assign fit = (q[QW-1:CW-1] == '0) || (q[QW-1:CW-1] == '1);

	always_ff @(posedge clk) begin
		if (ctl.adv[ST_8]) begin
			coord_s8 <= fit ? q[CW-1:0] : (q[QW-1] ? C_MIN : C_MAX);
			sat_s8   <= !fit;
		end
	end

	assign coord = coord_s8;
	assign sat   = sat_s8;

endmodule

`default_nettype wire

// File: hdl/affine_2d_vertex_transform.sv
// ----------------------------------------------------------------------------
// affine_2d_vertex_transform
// Homogeneous 2D vertex transform: translate, rotate about a pivot or scale.
//
// Input words on s_axis carry one vertex (x, y, w) in signed Q16.16; result
// words on m_axis carry the transformed x and y, the unchanged w, and in
// tuser a flag set when x, y or a rotation offset was saturated.
// Registers are written over the cfg channel (index, data); cfg_ready is
// always high. Write them only while no vertex is in flight.
// The datapath is an eight-stage pipeline: sine ROM read, quadrant fold,
// coefficient and pivot products, sums, pivot saturation, split wide
// product, accumulate, round and saturate. Every input word passes through
// all stages in order. One word per cycle is sustained while m_axis_tready is
// high. When m_axis_tready is low the last stage holds its word; empty stages
// upstream keep filling, and s_axis_tready drops only when every stage holds
// a word. Reset empties the pipeline and returns the registers to translate
// mode with zero offsets, zero angle and pivot, and a scale of 1.0.
// ----------------------------------------------------------------------------
`default_nettype none
`include "affine_2d_vertex_transform_macros.svh"

module affine_2d_vertex_transform
	import avt_pkg::*;
#(
	parameter int COORD_WIDTH     = 32,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// x_in, y_in, w_in
	input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// x_out, y_out, w_out
	output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// overflow
	output logic [0:0]                    m_axis_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [REG_IDX_W-1:0]          cfg_index,
	input  logic [COORD_WIDTH-1:0]        cfg_data
);

	localparam int CW    = COORD_WIDTH;
	localparam int DW    = ((3 * CW + 7) / 8) * 8;
	localparam logic signed [CW-1:0] SCALE_ONE = CW'(65536);

	mode_t                    mode_q;
	logic signed [CW-1:0]     offset_x_q;
	logic signed [CW-1:0]     offset_y_q;
	logic [ANGLE_W-1:0]       angle_q;
	logic signed [CW-1:0]     pivot_x_q;
	logic signed [CW-1:0]     pivot_y_q;
	logic signed [CW-1:0]     scale_q;

	stage_vec_t               vld_q;
	stage_vec_t               adv;
	pipe_ctl_t                ctl;
	logic                     in_acc;
	logic                     out_acc;

	logic signed [CW-1:0]     x_s1, x_s2, x_s3, x_s4, x_s5;
	logic signed [CW-1:0]     y_s1, y_s2, y_s3, y_s4, y_s5;
	logic signed [CW-1:0]     w_s1, w_s2, w_s3, w_s4, w_s5, w_s6, w_s7, w_s8;
	logic                     rsat_s6, rsat_s7, rsat_s8;

	logic signed [SC_W-1:0]   sin_v;
	logic signed [SC_W-1:0]   cos_v;
	logic signed [COEF_W-1:0] c2;
	logic signed [COEF_W-1:0] s2;
	logic signed [COEF_W-1:0] nx0, nx1, ny0, ny1;
	logic signed [CW-1:0]     tx, ty;
	logic                     piv_sat;
	logic signed [CW-1:0]     ax, ay, bx, by;
	logic signed [CW-1:0]     x_res, y_res;
	logic                     x_sat, y_sat;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_TRANSLATE;
			offset_x_q <= '0;
			offset_y_q <= '0;
			angle_q    <= '0;
			pivot_x_q  <= '0;
			pivot_y_q  <= '0;
			scale_q    <= SCALE_ONE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE:     mode_q     <= cfg_data[1:0];
				REG_OFFSET_X: offset_x_q <= cfg_data;
				REG_OFFSET_Y: offset_y_q <= cfg_data;
				REG_ANGLE:    angle_q    <= cfg_data[ANGLE_W-1:0];
				REG_PIVOT_X:  pivot_x_q  <= cfg_data;
				REG_PIVOT_Y:  pivot_y_q  <= cfg_data;
				REG_SCALE:    scale_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control: a stage loads when empty or when its successor loads
	always_comb begin
		adv[ST_8] = !vld_q[ST_8] || m_axis_tready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign ctl.adv       = adv;
	assign s_axis_tready = adv[ST_1];
	assign m_axis_tvalid = vld_q[ST_8];
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_acc       = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[ST_1]) begin
				vld_q[ST_1] <= s_axis_tvalid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// vertex delay lines
	always_ff @(posedge clk) begin
		if (adv[ST_1]) begin
			x_s1 <= s_axis_tdata[CW-1:0];
			y_s1 <= s_axis_tdata[2*CW-1:CW];
			w_s1 <= s_axis_tdata[3*CW-1:2*CW];
		end
		if (adv[ST_2]) begin
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			w_s2 <= w_s1;
		end
		if (adv[ST_3]) begin
			x_s3 <= x_s2;
			y_s3 <= y_s2;
			w_s3 <= w_s2;
		end
		if (adv[ST_4]) begin
			x_s4 <= x_s3;
			y_s4 <= y_s3;
			w_s4 <= w_s3;
		end
		if (adv[ST_5]) begin
			x_s5 <= x_s4;
			y_s5 <= y_s4;
			w_s5 <= w_s4;
		end
		if (adv[ST_6]) begin
			w_s6    <= w_s5;
			rsat_s6 <= (mode_q == MODE_ROTATE) && piv_sat;
		end
		if (adv[ST_7]) begin
			w_s7    <= w_s6;
			rsat_s7 <= rsat_s6;
		end
		if (adv[ST_8]) begin
			w_s8    <= w_s7;
			rsat_s8 <= rsat_s7;
		end
	end

	avt_sincos #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_sincos (
		.clk   (clk),
		.ctl   (ctl),
		.angle (angle_q),
		.sin_v (sin_v),
		.cos_v (cos_v)
	);

	avt_pivot #(
		.COORD_WIDTH (CW)
	) u_pivot (
		.clk     (clk),
		.ctl     (ctl),
		.sin_v   (sin_v),
		.cos_v   (cos_v),
		.pivot_x (pivot_x_q),
		.pivot_y (pivot_y_q),
		.tx      (tx),
		.ty      (ty),
		.sat     (piv_sat)
	);

	// linear part of the matrix
	assign c2 = COEF_W'(cos_v) <<< 1;
	assign s2 = COEF_W'(sin_v) <<< 1;

	always_comb begin
		unique case (mode_q) inside
			MODE_ROTATE: begin
				nx0 = c2;
				nx1 = -s2;
				ny0 = s2;
				ny1 = c2;
			end
			MODE_SCALE: begin
				nx0 = '0;
				nx1 = '0;
				ny0 = '0;
				ny1 = '0;
			end
			MODE_TRANSLATE, MODE_IDENTITY: begin
				nx0 = COEF_ONE;
				nx1 = '0;
				ny0 = '0;
				ny1 = COEF_ONE;
			end
			default: begin
				nx0 = '0;
				nx1 = '0;
				ny0 = '0;
				ny1 = '0;
			end
		endcase
	end

	// full-width operand of each row
	always_comb begin
		unique case (mode_q)
			MODE_TRANSLATE: begin
				ax = offset_x_q;
				ay = offset_y_q;
				bx = w_s5;
				by = w_s5;
			end
			MODE_ROTATE: begin
				ax = tx;
				ay = ty;
				bx = w_s5;
				by = w_s5;
			end
			MODE_SCALE: begin
				ax = scale_q;
				ay = scale_q;
				bx = x_s5;
				by = y_s5;
			end
			MODE_IDENTITY: begin
				ax = '0;
				ay = '0;
				bx = w_s5;
				by = w_s5;
			end
			default: begin
				ax = '0;
				ay = '0;
				bx = w_s5;
				by = w_s5;
			end
		endcase
	end

	avt_row #(
		.COORD_WIDTH (CW)
	) u_row_x (
		.clk    (clk),
		.ctl    (ctl),
		.coef_x (nx0),
		.coef_y (nx1),
		.vx     (x_s2),
		.vy     (y_s2),
		.mul_a  (ax),
		.mul_b  (bx),
		.coord  (x_res),
		.sat    (x_sat)
	);

	avt_row #(
		.COORD_WIDTH (CW)
	) u_row_y (
		.clk    (clk),
		.ctl    (ctl),
		.coef_x (ny0),
		.coef_y (ny1),
		.vx     (x_s2),
		.vy     (y_s2),
		.mul_a  (ay),
		.mul_b  (by),
		.coord  (y_res),
		.sat    (y_sat)
	);

	assign m_axis_tdata = DW'({w_s8, y_res, x_res});
	assign m_axis_tuser = x_sat || y_sat || rsat_s8;

	`AVT_ASSERT_NOW(a_stall_only_when_full, !s_axis_tready, &vld_q, "input stalled with a free stage")
	`AVT_ASSERT_NOW(a_occupancy, $past(arst_n), $countones(vld_q) == $past($countones(vld_q)) + $past(in_acc) - $past(out_acc), "pipeline occupancy lost or gained a word")
	`AVT_ASSERT_NEXT(a_out_from_last_stage, !m_axis_tvalid && !vld_q[ST_7], !m_axis_tvalid, "result word appeared without a predecessor")

endmodule

`default_nettype wire
